@@ sv/tabh_pkg.sv @@
package tabh_pkg;

  localparam int ScoreWidth = 48;
  localparam int ConflictWidth = 32;
  localparam int DecisionWidth = 40;
  localparam int TwentySteps = 5;

  typedef logic signed [ScoreWidth-1:0] score_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input transaction
    logic log_init;  // set up the log2 mantissa
    logic log_step;  // produce one fraction bit
    logic div_init;  // start the reward division
    logic div_step;  // one quotient bit
    logic upd_init;  // form the score update numerator
    logic [TwentySteps-1:0] tw_stage;  // one stage of the divide by twenty
    logic upd_done;  // round and saturate the new score
    logic fat_init;  // start the fatigue loop
    logic fat_mul;   // 19*s + 10
    logic fat_fix;   // apply floor correction of one fatigue step
    logic decide;    // compare and commit the arm choice
  } tabh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fat_last;  // no more fatigue steps are needed
  } tabh_sts_t;

endpackage

@@ sv/two_arm_bandit_heuristic_selector_top.sv @@
// Two-armed bandit heuristic selector.
// Input channel: in_valid/in_stall with phase_conflicts and phase_decisions,
// one transaction per finished solver phase.
// Output channel: out_valid/out_stall with chosen_arm, switched, score_active
// and score_idle, one transaction per input transaction.
// Configuration: cfg_we/cfg_data writes start_arm; it sets the active arm only
// until the first input transaction after reset.
// The result is formed in order by log2 squaring, the reward division, the
// score update, one fatigue factor for each step of run, where run is the stay
// count before the update (0 to 255), each factor using a divide by twenty,
// the last fatigue check and the decision.
// One transaction is in flight at a time; in_stall is high while busy, so a
// new input is not accepted until the result has been taken.
// Reset (rst, synchronous) clears scores, rewards, run count and selects arm 0.
// When the receiver stalls, the result holds on the outputs until taken and
// no new input is accepted.
module two_arm_bandit_heuristic_selector_top
  import tabh_pkg::*;
#(
  parameter int FRACTION_BITS = 32,
  parameter int STAY_COUNT_MAX = 255
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ConflictWidth-1:0] phase_conflicts,
  input  logic [DecisionWidth-1:0] phase_decisions,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     chosen_arm,
  output logic                     switched,
  output score_t                   score_active,
  output score_t                   score_idle
);

  tabh_cmd_t cmd;
  tabh_sts_t sts;
  logic busy;
  logic in_fire, out_fire;

  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;
  assign out_fire = out_valid && !out_stall;

  tabh_ctrl #(.FractionBits(FRACTION_BITS)) u_ctrl (
    .clk, .rst, .in_fire, .out_fire, .sts, .cmd, .busy, .out_valid
  );

  tabh_dp #(.FractionBits(FRACTION_BITS), .StayCountMax(STAY_COUNT_MAX)) u_dp (
    .clk, .rst, .cmd, .cfg_we, .cfg_data,
    .conflicts_in(phase_conflicts), .decisions_in(phase_decisions),
    .sts, .chosen_arm, .switched, .score_active, .score_idle
  );

endmodule

@@ sv/tabh_ctrl.sv @@
module tabh_ctrl
  import tabh_pkg::*;
#(
  parameter int FractionBits = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      out_fire,
  input  tabh_sts_t sts,
  output tabh_cmd_t cmd,
  output logic      busy,
  output logic      out_valid
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOGI = 4'd1;
  localparam logic [3:0] S_LOG  = 4'd2;
  localparam logic [3:0] S_DIVI = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_UMUL = 4'd5;
  localparam logic [3:0] S_UDV  = 4'd6;
  localparam logic [3:0] S_UEND = 4'd7;
  localparam logic [3:0] S_FCHK = 4'd8;
  localparam logic [3:0] S_FMUL = 4'd9;
  localparam logic [3:0] S_FDV  = 4'd10;
  localparam logic [3:0] S_FFIX = 4'd11;
  localparam logic [3:0] S_DEC  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  // Widest bit loop is the 64-bit reward division.
  localparam int CntW = 7;
  localparam int DivBits = 64;

  logic [3:0] state, state_next;
  logic [CntW-1:0] cnt, cnt_next;

  // State register and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Sequencing of the log2, divide, update and fatigue loops.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = S_LOGI;
        end
      end
      S_LOGI: begin
        cmd.log_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_LOG;
      end
      S_LOG: begin
        cmd.log_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CntW'(FractionBits - 1)) state_next = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CntW'(DivBits - 1)) state_next = S_UMUL;
      end
      S_UMUL: begin
        cmd.upd_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_UDV;
      end
      S_UDV: begin
        cmd.tw_stage = {{(TwentySteps-1){1'b0}}, 1'b1} << cnt;
        cnt_next     = cnt + 1'b1;
        if (cnt == CntW'(TwentySteps - 1)) state_next = S_UEND;
      end
      S_UEND: begin
        cmd.upd_done = 1'b1;
        cmd.fat_init = 1'b1;
        state_next   = S_FCHK;
      end
      S_FCHK: begin
        if (sts.fat_last) state_next = S_DEC;
        else state_next = S_FMUL;
      end
      S_FMUL: begin
        cmd.fat_mul = 1'b1;
        cnt_next    = '0;
        state_next  = S_FDV;
      end
      S_FDV: begin
        cmd.tw_stage = {{(TwentySteps-1){1'b0}}, 1'b1} << cnt;
        cnt_next     = cnt + 1'b1;
        if (cnt == CntW'(TwentySteps - 1)) state_next = S_FFIX;
      end
      S_FFIX: begin
        cmd.fat_fix = 1'b1;
        state_next  = S_FCHK;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy      = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

`ifndef NO_ASSERTIONS
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !busy) else $error("load outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_fire |=> out_valid) else $error("result dropped");
  a_after_out: assert property (@(posedge clk) disable iff (rst)
    out_fire |=> !busy) else $error("no return to idle");
`endif

endmodule

@@ sv/tabh_dp.sv @@
module tabh_dp
  import tabh_pkg::*;
#(
  parameter int FractionBits = 32,
  parameter int StayCountMax = 255
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tabh_cmd_t                cmd,
  input  logic                     cfg_we,
  input  logic                     cfg_data,
  input  logic [ConflictWidth-1:0] conflicts_in,
  input  logic [DecisionWidth-1:0] decisions_in,
  output tabh_sts_t                sts,
  output logic                     chosen_arm,
  output logic                     switched,
  output score_t                   score_active,
  output score_t                   score_idle
);

  localparam int StayW = $clog2(StayCountMax + 1);
  localparam int NumW = 60;   // 17*old + 3*(3R - 2P) plus rounding
  localparam logic signed [NumW-1:0] NumMax = (NumW'(1) <<< (ScoreWidth - 1)) - NumW'(1);
  localparam logic signed [NumW-1:0] NumMin = -(NumW'(1) <<< (ScoreWidth - 1));

  logic stepped;
  logic arm;
  logic [StayW-1:0] stay, fat_cnt;
  score_t score [2];
  score_t prev_r [2];

  logic [ConflictWidth:0] x;
  logic [DecisionWidth:0] dplus;
  logic [5:0] e;
  logic [31:0] m;
  logic [FractionBits-1:0] frac;
  logic [63:0] div_num, div_q;
  logic [DecisionWidth:0] div_rem;
  score_t r_val;

  logic numer_neg;
  logic [NumW-1:0] tw_mag, tw_q;
  logic [4:0] tw_r;
  logic tw_nz;
  score_t s_val;

  // Top set bit of c+1.
  logic [5:0] e_calc;
  always_comb begin
    e_calc = '0;
    for (int i = 0; i <= ConflictWidth; i++) begin
      if (x[i]) e_calc = 6'(i);
    end
  end

  // Log mantissa squaring step; the mantissa stays below 2^32.
  logic [63:0] msq;
  assign msq = (64'(m) * 64'(m)) >> 31;

  // Restoring division step for the reward.
  logic [DecisionWidth+1:0] div_trial;
  assign div_trial = {div_rem, div_num[63]} - {1'b0, dplus};

  // The reward is the quotient of the division.
  assign r_val = div_q[ScoreWidth-1:0];

  // Divide by twenty: drop two bits, then a reciprocal series for the divide by five.
  logic [NumW-1:0] tw_b, tw_a1, tw_a2;
  assign tw_b  = tw_mag >> 2;
  assign tw_a1 = (tw_b >> 1) + (tw_b >> 2);
  assign tw_a2 = tw_q + (tw_q >> 8);

  // The series falls short of the quotient by a small amount; fix it from the remainder.
  logic [1:0] tw_corr;
  logic [4:0] tw_taken;
  always_comb begin
    priority if (tw_r >= 5'd15) begin
      tw_corr  = 2'd3;
      tw_taken = 5'd15;
    end else if (tw_r >= 5'd10) begin
      tw_corr  = 2'd2;
      tw_taken = 5'd10;
    end else if (tw_r >= 5'd5) begin
      tw_corr  = 2'd1;
      tw_taken = 5'd5;
    end else begin
      tw_corr  = 2'd0;
      tw_taken = 5'd0;
    end
  end

  // Result of a floor divide by twenty with signed numerator.
  logic signed [NumW-1:0] tw_floor;
  always_comb begin
    if (!numer_neg) tw_floor = $signed(tw_q);
    else if (tw_nz) tw_floor = -$signed(tw_q) - NumW'(1);
    else tw_floor = -$signed(tw_q);
  end

  logic signed [NumW-1:0] sat_val;
  always_comb begin
    if (tw_floor > NumMax) sat_val = NumMax;
    else if (tw_floor < NumMin) sat_val = NumMin;
    else sat_val = tw_floor;
  end

  // Numerator for the score update: 17*old + 3*(3R - 2P) + 10.
  logic signed [NumW-1:0] upd_num;
  assign upd_num = NumW'(score[arm]) * 17 + (NumW'(r_val) * 9)
                 - (NumW'(prev_r[arm]) * 6) + NumW'(10);
  logic signed [NumW-1:0] fat_num;
  assign fat_num = NumW'(s_val) * 19 + NumW'(10);

  // Decision terms.
  score_t so;
  logic signed [ScoreWidth+5:0] so20, s23;
  logic sw;
  assign so   = score[~arm];
  assign so20 = (ScoreWidth+6)'(so) * 20;
  assign s23  = (ScoreWidth+6)'(s_val) * 23;
  assign sw   = (so > s_val) && ((stay >= StayW'(2)) || (so20 > s23));

  assign sts.fat_last = (fat_cnt == stay);

  always_ff @(posedge clk) begin
    if (rst) begin
      stepped   <= 1'b0;
      arm       <= 1'b0;
      stay      <= '0;
      score[0]  <= '0;
      score[1]  <= '0;
      prev_r[0] <= '0;
      prev_r[1] <= '0;
    end else begin
      // Start arm loads only before the first transaction.
      if (cfg_we && !stepped) arm <= cfg_data;
      if (cmd.load) stepped <= 1'b1;
      if (cmd.upd_done) begin
        score[arm]  <= sat_val[ScoreWidth-1:0];
        prev_r[arm] <= r_val;
      end
      if (cmd.decide) begin
        if (sw) begin
          arm  <= ~arm;
          stay <= '0;
        end else if (stay < StayW'(StayCountMax)) begin
          stay <= stay + 1'b1;
        end
      end
    end
  end

  // Datapath payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x     <= {1'b0, conflicts_in} + 1'b1;
      dplus <= {1'b0, decisions_in} + 1'b1;
    end
    if (cmd.log_init) begin
      e <= e_calc;
      m <= (e_calc <= 6'd31) ? 32'(x << (6'd31 - e_calc)) : 32'(x >> (e_calc - 6'd31));
      frac <= '0;
    end
    if (cmd.log_step) begin
      if (msq[32]) begin
        m    <= msq[32:1];
        frac <= {frac[FractionBits-2:0], 1'b1};
      end else begin
        m    <= msq[31:0];
        frac <= {frac[FractionBits-2:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      div_num <= 64'({e, frac});
      div_rem <= '0;
      div_q   <= '0;
    end
    if (cmd.div_step) begin
      div_num <= {div_num[62:0], 1'b0};
      if (!div_trial[DecisionWidth+1]) begin
        div_rem <= div_trial[DecisionWidth:0];
        div_q   <= {div_q[62:0], 1'b1};
      end else begin
        div_rem <= {div_rem[DecisionWidth-1:0], div_num[63]};
        div_q   <= {div_q[62:0], 1'b0};
      end
    end
    if (cmd.upd_init) begin
      numer_neg <= upd_num[NumW-1];
      tw_mag    <= upd_num[NumW-1] ? NumW'(-upd_num) : NumW'(upd_num);
    end
    if (cmd.fat_mul) begin
      numer_neg <= fat_num[NumW-1];
      tw_mag    <= fat_num[NumW-1] ? NumW'(-fat_num) : NumW'(fat_num);
    end
    // Divide by twenty, one stage per cycle.
    if (cmd.tw_stage[0]) tw_q <= tw_a1 + (tw_a1 >> 4);
    if (cmd.tw_stage[1]) tw_q <= tw_a2 + (tw_a2 >> 16);
    if (cmd.tw_stage[2]) tw_q <= (tw_q + (tw_q >> 32)) >> 2;
    if (cmd.tw_stage[3]) tw_r <= 5'(tw_b - (tw_q << 2) - tw_q);
    if (cmd.tw_stage[4]) begin
      tw_q  <= tw_q + NumW'(tw_corr);
      tw_nz <= (tw_mag[1:0] != 2'd0) || (tw_r != tw_taken);
    end
    if (cmd.upd_done) s_val <= sat_val[ScoreWidth-1:0];
    if (cmd.fat_init) fat_cnt <= '0;
    if (cmd.fat_fix) begin
      s_val   <= tw_floor[ScoreWidth-1:0];
      fat_cnt <= fat_cnt + 1'b1;
    end
    if (cmd.decide) begin
      chosen_arm   <= sw ? ~arm : arm;
      switched     <= sw;
      score_active <= s_val;
      score_idle   <= so;
    end
  end

`ifndef NO_ASSERTIONS
  a_stay_max: assert property (@(posedge clk) disable iff (rst)
    stay <= StayW'(StayCountMax)) else $error("run count overflow");
  a_switch_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.decide && sw |=> stay == '0) else $error("run not cleared");
  a_arm_flip: assert property (@(posedge clk) disable iff (rst)
    cmd.decide && sw |=> arm != $past(arm)) else $error("arm not switched");
`endif

endmodule
